[sv/eet_pkg.sv]
// ----------------------------------------------------------------------------
// eet_pkg: shared types and codes for the expiring entry table
// Request and response item layouts, action and status codes, slot word
// layout and the default table depth.
// ----------------------------------------------------------------------------
package eet_pkg;

  localparam int SLOT_COUNT_DEF = 256;

  localparam logic [31:0] FRAME_MAX = 32'hFFFF_FFFF;
  localparam logic [8:0]  FREED_MAX = 9'h1FF;

  // action codes
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;
  localparam logic [1:0] ACT_NOP    = 2'd3;

  // status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_DONE     = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] owner_ref;
    logic [30:0]        lifetime;
  } req_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] slot_index;
    logic [8:0] freed_count;
  } rsp_item_t;

  // one table slot as stored in the slot memory
  typedef struct packed {
    logic        valid;
    logic [31:0] owner;
    logic [31:0] expiry;
  } slot_word_t;

endpackage

[sv/eet_slot_mem.sv]
// ----------------------------------------------------------------------------
// eet_slot_mem: slot storage
// One write port and one registered read port, one slot word per entry.
// ----------------------------------------------------------------------------
module eet_slot_mem #(
  parameter int DEPTH = eet_pkg::SLOT_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  eet_pkg::slot_word_t        wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output eet_pkg::slot_word_t        rd_data
);

  eet_pkg::slot_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/eet_slot_eval.sv]
// ----------------------------------------------------------------------------
// eet_slot_eval: shared slot compare unit
// Shared 32-bit operands: owner match for remove, expiry below frame for tick.
// ----------------------------------------------------------------------------
module eet_slot_eval (
  input  logic [1:0]          op,
  input  eet_pkg::slot_word_t word,
  input  logic [31:0]         owner_key,
  input  logic [31:0]         frame,
  output logic                hit
);

  logic [31:0] lhs;
  logic [31:0] rhs;
  logic        match;
  logic        below;

  // operand select, then an equal and a less-than compare
  always_comb begin
    lhs = word.expiry;
    rhs = frame;
    if (op == eet_pkg::ACT_REMOVE) begin
      lhs = word.owner;
      rhs = owner_key;
    end
  end

  assign match = (lhs == rhs);
  assign below = (lhs < rhs);

  always_comb begin
    case (op)
      eet_pkg::ACT_REMOVE: hit = word.valid && match;
      eet_pkg::ACT_TICK:   hit = word.valid && below;
      default:             hit = 1'b0;
    endcase
  end

endmodule

[sv/expiring_entry_table.sv]
// ----------------------------------------------------------------------------
// expiring_entry_table: slot table with timeout aging
// Fixed table of slots with owner reference and expiry frame, frame counter.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one action: insert,
//   remove by owner reference, or tick one frame. rsp channel (rsp_valid /
//   rsp_stall / rsp) returns exactly one result per request transfer.
//   After reset the block runs a clearing pass over every slot of the
//   slot memory and holds req_stall high meanwhile.
//   Remove, tick and a full insert scan every slot, one memory read per
//   cycle. An insert stops at the lowest free slot. The undefined action
//   skips the scan and changes nothing.
//   One request is handled per scan: the next request is taken only once
//   the scan has ended and its result has left the sequencer; the
//   sequencer, the slot memory read port and the shared compare unit set
//   that limit.
//   The result sits in an output register; a new request is taken while it
//   waits. If the receiver still stalls when the next result is ready, the
//   sequencer holds that result and keeps req_stall high until it moves.
// ----------------------------------------------------------------------------
module expiring_entry_table #(
  parameter int SLOT_COUNT = eet_pkg::SLOT_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  eet_pkg::req_item_t  req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output eet_pkg::rsp_item_t  rsp
);

  localparam int AW = $clog2(SLOT_COUNT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(SLOT_COUNT - 1);

  // sequencer states
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_POST  = 2'd3;

  logic [1:0]          state;
  logic [AW-1:0]       scan_addr;   // read pointer, also clear pointer
  logic                issue_done;
  logic                pend;        // rd_data holds the slot at pend_addr
  logic [AW-1:0]       pend_addr;
  logic                pend_last;
  logic [1:0]          op;
  logic [31:0]         owner_key;
  logic [31:0]         ins_expiry;
  logic [31:0]         frame_count;
  logic [8:0]          freed;
  eet_pkg::rsp_item_t  res;

  logic                rd_en;
  eet_pkg::slot_word_t rd_data;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  eet_pkg::slot_word_t wr_data;
  logic                hit;
  logic                ins_take;
  logic [8:0]          freed_next;
  logic [32:0]         exp_sum;
  logic [31:0]         exp_sat;
  logic [31:0]         pend_addr_w;
  logic                rsp_load;    // result moves into the output register

  assign req_stall = (state != S_IDLE);

  // insert expiry: frame + lifetime, saturating
  assign exp_sum = {1'b0, frame_count} + 33'(req.lifetime);
  assign exp_sat = exp_sum[32] ? eet_pkg::FRAME_MAX : exp_sum[31:0];

  assign pend_addr_w = 32'(pend_addr);

  assign rd_en = (state == S_SCAN) && !issue_done;

  assign rsp_load = (state == S_POST) && (!rsp_valid || !rsp_stall);

  eet_slot_eval u_eval (
    .op        (op),
    .word      (rd_data),
    .owner_key (owner_key),
    .frame     (frame_count),
    .hit       (hit)
  );

  assign ins_take = (op == eet_pkg::ACT_INSERT) && !rd_data.valid;

  always_comb begin
    freed_next = freed;
    if (hit && (freed != eet_pkg::FREED_MAX)) begin
      freed_next = freed + 9'd1;
    end
  end

  // write port: clearing pass, insert fill, or free on hit
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_addr;
    wr_data = rd_data;
    wr_data.valid = 1'b0;
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = scan_addr;
      wr_data = '0;
    end else if ((state == S_SCAN) && pend) begin
      if (op == eet_pkg::ACT_INSERT) begin
        wr_en          = ins_take;
        wr_data.valid  = 1'b1;
        wr_data.owner  = owner_key;
        wr_data.expiry = ins_expiry;
      end else begin
        wr_en = hit;
      end
    end
  end

  eet_slot_mem #(
    .DEPTH (SLOT_COUNT)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (scan_addr),
    .rd_data (rd_data)
  );

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          op         <= req.action;
          owner_key  <= req.owner_ref;
          ins_expiry <= exp_sat;
          freed      <= '0;
          res        <= '{status: eet_pkg::ST_DONE, slot_index: 8'd0, freed_count: 9'd0};
        end
      end
      S_SCAN: begin
        pend_addr <= scan_addr;
        pend_last <= (scan_addr == LAST_ADDR);
        if (pend) begin
          freed <= freed_next;
          if (op == eet_pkg::ACT_INSERT) begin
            if (ins_take) begin
              res <= '{status: eet_pkg::ST_INSERTED, slot_index: pend_addr_w[7:0],
                       freed_count: 9'd0};
            end else if (pend_last) begin
              res <= '{status: eet_pkg::ST_FULL, slot_index: 8'd0, freed_count: 9'd0};
            end
          end else if (pend_last) begin
            res <= '{status: eet_pkg::ST_DONE, slot_index: 8'd0, freed_count: freed_next};
          end
        end
      end
      S_POST: begin
        if (rsp_load) begin
          rsp <= res;
        end
      end
      default: begin
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      scan_addr   <= '0;
      issue_done  <= 1'b0;
      pend        <= 1'b0;
      rsp_valid   <= 1'b0;
      frame_count <= '0;
    end else begin
      // rd_en is low outside the scan, so pend drops there
      pend      <= rd_en;
      rsp_valid <= rsp_load || (rsp_valid && rsp_stall);
      unique case (state)
        S_CLEAR: begin
          if (scan_addr == LAST_ADDR) begin
            scan_addr <= '0;
            state     <= S_IDLE;
          end else begin
            scan_addr <= scan_addr + AW'(1);
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            scan_addr  <= '0;
            issue_done <= 1'b0;
            if ((req.action == eet_pkg::ACT_TICK) && (frame_count != eet_pkg::FRAME_MAX)) begin
              frame_count <= frame_count + 32'd1;
            end
            if (req.action == eet_pkg::ACT_NOP) begin
              state <= S_POST;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (rd_en) begin
            scan_addr <= scan_addr + AW'(1);
            if (scan_addr == LAST_ADDR) begin
              issue_done <= 1'b1;
            end
          end
          if (pend && (ins_take || pend_last)) begin
            state <= S_POST;
          end
        end
        S_POST: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[tb/sv/expiring_entry_table_tb.sv]
// ----------------------------------------------------------------------------
// expiring_entry_table_tb: self-checking bench for the expiring entry table
// Drives insert, remove, tick and undefined actions through the request
// channel, and keeps its own copy of the slot table and frame counter.
// Every response transfer is checked field by field against the oldest
// predicted result. Both sides idle at random, apart from one stretch that
// runs back to back.
// ----------------------------------------------------------------------------
module expiring_entry_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import eet_pkg::*;

  localparam int SLOTS         = SLOT_COUNT_DEF;
  localparam int IDLE_PCT      = 38;
  // Longest correct quiet spell is about one full scan plus a short
  // receiver stall, or the clearing pass after reset. The limit leaves a
  // wide margin over both.
  localparam int WATCHDOG_MAX  = 30 * (SLOTS + 3);
  // Mismatch lines stop printing past this many; counting goes on.
  localparam int REPORT_MAX    = 100;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_item_t req       = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp;

  // calm = 1 turns off idling on both sides
  bit        calm = 1'b0;
  int        mismatch_count = 0;
  int        quiet_cycles   = 0;

  // results predicted at request transfer, oldest first
  rsp_item_t owed_rsp[$];

  // bench copy of the slot table
  bit          tbl_valid  [SLOTS];
  logic [31:0] tbl_owner  [SLOTS];
  logic [31:0] tbl_expiry [SLOTS];
  logic [31:0] frame_now = '0;

  always #1 clk = ~clk;

  expiring_entry_table #(
    .SLOT_COUNT(SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  // --------------------------------------------------------------------------
  // Table prediction
  // --------------------------------------------------------------------------

  // Applies one request to the bench table and returns the result it owes.
  // Expiry saturation and the frame counter sticking at its maximum are
  // covered here, though no run of this length gets the counter that far.
  function automatic rsp_item_t table_update(input req_item_t r);
    rsp_item_t   o;
    logic [32:0] sum;
    int unsigned freed;
    bit          placed;
    o      = '0;
    freed  = 0;
    placed = 1'b0;
    case (r.action)
      ACT_INSERT: begin
        o.status = ST_FULL;
        for (int i = 0; i < SLOTS; i++) begin
          if (!placed && !tbl_valid[i]) begin
            sum           = {1'b0, frame_now} + {2'b00, r.lifetime};
            tbl_valid[i]  = 1'b1;
            tbl_owner[i]  = r.owner_ref;
            tbl_expiry[i] = sum[32] ? FRAME_MAX : sum[31:0];
            o.status      = ST_INSERTED;
            o.slot_index  = 8'(i);
            placed        = 1'b1;
          end
        end
      end
      ACT_REMOVE: begin
        o.status = ST_DONE;
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i] && tbl_owner[i] == r.owner_ref) begin
            tbl_valid[i] = 1'b0;
            freed++;
          end
        end
      end
      ACT_TICK: begin
        o.status = ST_DONE;
        if (frame_now != FRAME_MAX) frame_now = frame_now + 1;
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i] && tbl_expiry[i] < frame_now) begin
            tbl_valid[i] = 1'b0;
            freed++;
          end
        end
      end
      default: begin
        // undefined action: nothing changes
        o.status = ST_DONE;
      end
    endcase
    if (o.status == ST_DONE)
      o.freed_count = (freed > FREED_MAX) ? FREED_MAX : 9'(freed);
    return o;
  endfunction

  function automatic int used_slots();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) n += tbl_valid[i];
    return n;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic req_item_t req_of(input logic [1:0] act, input logic [31:0] owner,
                                       input logic [30:0] life);
    req_item_t r;
    r.action    = act;
    r.owner_ref = owner;
    r.lifetime  = life;
    return r;
  endfunction

  // Mostly a small pool of owners so removes hit several slots at once;
  // now and then a fully random pattern.
  function automatic logic [31:0] pick_owner();
    if ($urandom_range(0, 99) < 15) return $urandom;
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h0000_0001;
      5:       return 32'h0F0F_F0F0;
      6:       return 32'hA5A5_5A5A;
      default: return 32'h3C00_00C3;
    endcase
  endfunction

  // Short lifetimes so ticks expire entries; some long ones that linger.
  function automatic logic [30:0] pick_lifetime();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 31'($urandom_range(0, 12));
    if (roll < 90) return 31'($urandom_range(0, 300));
    return 31'($urandom);
  endfunction

  function automatic req_item_t pick_req();
    int unsigned roll;
    logic [1:0]  act;
    roll = $urandom_range(0, 99);
    if (roll < 45)      act = ACT_INSERT;
    else if (roll < 65) act = ACT_REMOVE;
    else if (roll < 95) act = ACT_TICK;
    else                act = ACT_NOP;
    return req_of(act, pick_owner(), pick_lifetime());
  endfunction

  // One request transfer. valid stays high on return so a following
  // back-to-back transfer never drops it within the same step.
  task automatic send_req(input req_item_t item);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
    owed_rsp.push_back(table_update(item));
  endtask

  task automatic report_mismatch(input string what);
    if (mismatch_count < REPORT_MAX) $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes, every action, slot reuse, expiry of lifetime-0 entries,
  // removes with and without a match, and the undefined action.
  task automatic test_edges();
    send_req(req_of(ACT_NOP,    32'hFFFF_FFFF, 31'h7FFF_FFFF));
    send_req(req_of(ACT_TICK,   32'h0000_0000, 31'h0));          // empty table
    send_req(req_of(ACT_REMOVE, 32'h0000_0000, 31'h0));          // empty table
    send_req(req_of(ACT_INSERT, 32'h8000_0000, 31'h0));          // slot 0
    send_req(req_of(ACT_INSERT, 32'h7FFF_FFFF, 31'h7FFF_FFFF));  // slot 1
    send_req(req_of(ACT_INSERT, 32'hFFFF_FFFF, 31'h1));          // slot 2
    send_req(req_of(ACT_INSERT, 32'h0000_0000, 31'h0));          // slot 3
    send_req(req_of(ACT_INSERT, 32'h8000_0000, 31'h2));          // slot 4
    send_req(req_of(ACT_REMOVE, 32'h8000_0001, 31'h7FFF_FFFF));  // no match
    send_req(req_of(ACT_TICK,   32'h5555_5555, 31'h5555_5555));  // frees 0 and 3
    send_req(req_of(ACT_INSERT, 32'h5555_5555, 31'h2AAA_AAAA));  // reuses slot 0
    send_req(req_of(ACT_INSERT, 32'hAAAA_AAAA, 31'h5555_5555));  // reuses slot 3
    send_req(req_of(ACT_REMOVE, 32'h8000_0000, 31'h0));
    send_req(req_of(ACT_TICK,   32'h0000_0000, 31'h0));          // frees slot 2
    send_req(req_of(ACT_NOP,    32'h0000_0000, 31'h0));
    send_req(req_of(ACT_REMOVE, 32'h7FFF_FFFF, 31'h0));
    send_req(req_of(ACT_REMOVE, 32'h5555_5555, 31'h0));
    send_req(req_of(ACT_REMOVE, 32'hAAAA_AAAA, 31'h0));
  endtask

  // Fill every slot, hit the full case, free a few by expiry and refill,
  // then drain by owner until the table is empty.
  task automatic test_fill_and_drain();
    int first;
    while (used_slots() < SLOTS)
      send_req(req_of(ACT_INSERT, pick_owner(), pick_lifetime()));
    send_req(req_of(ACT_INSERT, 32'hFFFF_FFFF, 31'h7FFF_FFFF));
    send_req(req_of(ACT_INSERT, 32'h0000_0000, 31'h0));
    send_req(req_of(ACT_TICK, pick_owner(), pick_lifetime()));
    send_req(req_of(ACT_TICK, pick_owner(), pick_lifetime()));
    while (used_slots() < SLOTS)
      send_req(req_of(ACT_INSERT, pick_owner(), pick_lifetime()));
    send_req(req_of(ACT_INSERT, pick_owner(), pick_lifetime()));
    while (used_slots() > 0) begin
      first = 0;
      while (!tbl_valid[first]) first++;
      send_req(req_of(ACT_REMOVE, tbl_owner[first], pick_lifetime()));
    end
  endtask

  // Whole table at lifetime 0, then one tick frees all of it at once.
  task automatic test_expire_all();
    while (used_slots() < SLOTS)
      send_req(req_of(ACT_INSERT, pick_owner(), 31'h0));
    send_req(req_of(ACT_TICK, pick_owner(), pick_lifetime()));
  endtask

  // Back-to-back stretch: neither side idles.
  task automatic test_streaming(input int count);
    calm = 1'b1;
    repeat (count) send_req(pick_req());
    calm = 1'b0;
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_req(pick_req());
  endtask

  // --------------------------------------------------------------------------
  // Response check, receiver stalls and watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : rsp_side
    rsp_item_t want;
    if (rst) begin
      rsp_stall    <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (rsp_valid === 1'b1 && !rsp_stall) begin
        if (owed_rsp.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: %p", rsp));
        end else begin
          want = owed_rsp.pop_front();
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
          if (rsp.slot_index !== want.slot_index)
            report_mismatch($sformatf("slot_index %0d, expected %0d",
                                      rsp.slot_index, want.slot_index));
          if (rsp.freed_count !== want.freed_count)
            report_mismatch($sformatf("freed_count %0d, expected %0d",
                                      rsp.freed_count, want.freed_count));
        end
      end
      rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      // any transfer on either channel counts as progress
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $display("%0t ns: no transfer for %0d cycles", $time, quiet_cycles);
        $display("expiring_entry_table_tb NOT OK");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // the block's clearing pass holds req_stall; send_req waits it out
    test_edges();
    test_fill_and_drain();
    test_expire_all();
    test_streaming(150);
    test_random_mix(900);
    req_valid <= 1'b0;

    // drain, then one more scan's worth of cycles for stray results
    while (owed_rsp.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("expiring_entry_table_tb OK");
    end else begin
      $display("expiring_entry_table_tb NOT OK");
    end
    $finish;
  end

endmodule
